FILE: rtl/count_sketch_top_k_tracker_defines.svh
// assertion macros shared by the count sketch tracker modules
`ifndef COUNT_SKETCH_TOP_K_TRACKER_DEFINES_SVH
`define COUNT_SKETCH_TOP_K_TRACKER_DEFINES_SVH

// same-cycle implication, sampled on clk, idle during reset
`define CST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, sampled on clk, idle during reset
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/cst_pkg.sv
// shared command codes and result type for the count sketch tracker
`timescale 1ns / 1ps
package cst_pkg;

	typedef enum logic [1:0] {
		CMD_UPDATE = 2'd0,
		CMD_REPORT = 2'd1,
		CMD_CLEAR  = 2'd2
	} cst_cmd_t;

	typedef struct packed {
		logic               valid;
		logic [31:0]        key;
		logic signed [31:0] est;
		logic               top;
		logic               last;
	} cst_res_t;

endpackage

FILE: rtl/cst_front.sv
// front end: request intake, bucket folding and a two-entry queue
`timescale 1ns / 1ps
module cst_front #(
	parameter int ROWS    = 5,
	parameter int BUCKETS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   cmd,
	input  logic [31:0]                  item_key,
	input  logic signed [31:0]           weight,
	input  logic [9:0]                   bucket_row0,
	input  logic [9:0]                   bucket_row1,
	input  logic [9:0]                   bucket_row2,
	input  logic [9:0]                   bucket_row3,
	input  logic [9:0]                   bucket_row4,
	input  logic [4:0]                   sign_bits,
	output logic                         q_valid,
	input  logic                         q_pop,
	output logic [1:0]                   q_cmd,
	output logic [31:0]                  q_key,
	output logic signed [31:0]           q_weight,
	output logic [ROWS-1:0][$clog2(BUCKETS)-1:0] q_addr,
	output logic [ROWS-1:0]              q_neg
);
	localparam int BW    = $clog2(BUCKETS);
	localparam int RECIP = (1 << 20) / BUCKETS;

	logic [4:0][9:0]          bk;
	logic [ROWS-1:0][BW-1:0]  addr;
	logic [ROWS-1:0]          neg;

	logic [1:0]               f_cmd_q   [2];
	logic [31:0]              f_key_q   [2];
	logic signed [31:0]       f_w_q     [2];
	logic [ROWS-1:0][BW-1:0]  f_addr_q  [2];
	logic [ROWS-1:0]          f_neg_q   [2];
	logic                     wr_ptr_q, rd_ptr_q;
	logic [1:0]               cnt_q;
	logic                     push;

	assign bk = {bucket_row4, bucket_row3, bucket_row2, bucket_row1, bucket_row0};

	// bucket modulo by reciprocal multiply, one correction step
	for (genvar r = 0; r < ROWS; r++) begin : g_row
		if (r < 5) begin : g_in
			logic [30:0] prod;
			logic [10:0] quo;
			logic [27:0] rem;
			always_comb begin
				prod = 31'(bk[r]) * 31'(RECIP);
				quo  = prod[30:20];
				rem  = 28'(bk[r]) - 28'(quo) * 28'(BUCKETS);
				if (rem >= 28'(BUCKETS)) begin
					rem = rem - 28'(BUCKETS);
				end
				addr[r] = BW'(rem);
				neg[r]  = sign_bits[r];
			end
		end else begin : g_extra
			assign addr[r] = '0;
			assign neg[r]  = 1'b0;
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = f_cmd_q[rd_ptr_q];
	assign q_key    = f_key_q[rd_ptr_q];
	assign q_weight = f_w_q[rd_ptr_q];
	assign q_addr   = f_addr_q[rd_ptr_q];
	assign q_neg    = f_neg_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			f_cmd_q[wr_ptr_q]  <= cmd;
			f_key_q[wr_ptr_q]  <= item_key;
			f_w_q[wr_ptr_q]    <= weight;
			f_addr_q[wr_ptr_q] <= addr;
			f_neg_q[wr_ptr_q]  <= neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

	`include "count_sketch_top_k_tracker_defines.svh"

	`CST_ASSERT_NOW(fifo_cnt_bound, 1'b1, cnt_q <= 2'd2, "queue count overflow")

endmodule

FILE: rtl/cst_back.sv
// back end: sketch memories, heap memory and the update/report sequencer
`timescale 1ns / 1ps
module cst_back #(
	parameter int ROWS         = 5,
	parameter int BUCKETS      = 1024,
	parameter int TOP_K        = 16,
	parameter int COUNTER_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	output logic                                 q_pop,
	input  logic [1:0]                           q_cmd,
	input  logic [31:0]                          q_key,
	input  logic signed [31:0]                   q_weight,
	input  logic [ROWS-1:0][$clog2(BUCKETS)-1:0] q_addr,
	input  logic [ROWS-1:0]                      q_neg,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output cst_pkg::cst_res_t                    res
);
	localparam int CB = COUNTER_BITS;
	localparam int BW = $clog2(BUCKETS);
	localparam int LW = $clog2(TOP_K + 1);
	localparam int IW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
	localparam int W  = ((CB > 33) ? CB : 33) + 1;
	localparam int EW = (CB > 32) ? CB : 32;
	localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic signed [W-1:0]  LMAX = W'(CMAX);
	localparam logic signed [W-1:0]  LMIN = W'(CMIN);
	localparam logic signed [EW-1:0] EMAX = EW'(33'sh07fffffff);
	localparam logic signed [EW-1:0] EMIN = -EMAX - EW'(1);

	typedef enum logic [4:0] {
		S_SWP, S_IDLE, S_RD, S_OLD, S_NEW, S_ROOT, S_SRCH, S_SCHK, S_INS,
		S_UP, S_UPC, S_DN, S_DNL, S_DNR, S_FIN, S_EMIT, S_REP, S_REPE, S_MARK
	} state_t;

	state_t                   state_q;
	logic [BW-1:0]            sweep_q;
	logic [LW-1:0]            len_q;
	logic [IW-1:0]            idx_q;
	logic                     search_q, scan_q, top_q, out_valid_q;
	cst_pkg::cst_res_t        res_q;
	logic [1:0]               it_cmd_q;
	logic [31:0]              it_key_q;
	logic signed [31:0]       it_w_q;
	logic [ROWS-1:0][BW-1:0]  it_addr_q;
	logic [ROWS-1:0]          it_neg_q;
	logic signed [CB-1:0]     old_est_q, new_est_q, root_est_q, cur_est_q, lft_est_q;
	logic [31:0]              cur_key_q, lft_key_q;
	logic signed [CB-1:0]     nv_q   [ROWS];
	logic signed [CB-1:0]     rd_q   [ROWS];
	logic signed [CB-1:0]     old_v  [ROWS];
	logic signed [CB-1:0]     new_c  [ROWS];
	logic signed [CB-1:0]     new_v  [ROWS];
	logic signed [CB-1:0]     h_est  [TOP_K];
	logic [31:0]              h_key  [TOP_K];
	logic signed [CB-1:0]     hr_est_q;
	logic [31:0]              hr_key_q;
	logic [IW-1:0]            hr_addr, hw_addr, parent;
	logic                     hw_en, cnt_we, out_free, last_idx;
	logic signed [CB-1:0]     hw_est;
	logic [31:0]              hw_key;
	logic [LW:0]              lc, rc;
	logic                     l_ok, r_ok;

	function automatic logic signed [CB-1:0] cneg(input logic signed [CB-1:0] c);
		return (c == CMIN) ? CMAX : -c;
	endfunction

	function automatic logic signed [CB-1:0] sat_add(input logic signed [CB-1:0] c,
			input logic signed [31:0] w, input logic n);
		logic signed [W-1:0] d;
		logic signed [W-1:0] s;
		d = W'(w);
		s = W'(c) + (n ? -d : d);
		if (s > LMAX) begin
			return CMAX;
		end
		if (s < LMIN) begin
			return CMIN;
		end
		return s[CB-1:0];
	endfunction

	// rank select: the element with exactly ROWS/2 below it
	function automatic logic signed [CB-1:0] med(input logic signed [CB-1:0] v [ROWS]);
		logic [2:0]           rk;
		logic signed [CB-1:0] m;
		m = v[0];
		for (int i = 0; i < ROWS; i++) begin
			rk = 3'd0;
			for (int j = 0; j < ROWS; j++) begin
				if (v[j] < v[i] || (j < i && v[j] == v[i])) begin
					rk = rk + 3'd1;
				end
			end
			if (rk == 3'(ROWS / 2)) begin
				m = v[i];
			end
		end
		return m;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [CB-1:0] e);
		logic signed [EW-1:0] x;
		x = EW'(e);
		if (x > EMAX) begin
			x = EMAX;
		end
		if (x < EMIN) begin
			x = EMIN;
		end
		return x[31:0];
	endfunction

	function automatic logic less(input logic signed [CB-1:0] ae, input logic [31:0] ak,
			input logic signed [CB-1:0] be, input logic [31:0] bk);
		return (ae != be) ? (ae < be) : (ak < bk);
	endfunction

	// counter read, signed view and saturating update per row
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			old_v[r] = it_neg_q[r] ? cneg(rd_q[r]) : rd_q[r];
			new_c[r] = sat_add(rd_q[r], it_w_q, it_neg_q[r]);
			new_v[r] = it_neg_q[r] ? cneg(new_c[r]) : new_c[r];
		end
	end

	assign cnt_we = (state_q == S_SWP) || (state_q == S_OLD);

	for (genvar r = 0; r < ROWS; r++) begin : g_mem
		logic signed [CB-1:0] cnt_mem [BUCKETS];
		logic [BW-1:0]        wa;
		assign wa = (state_q == S_SWP) ? sweep_q : it_addr_q[r];
		always_ff @(posedge clk) begin
			if (cnt_we) begin
				cnt_mem[wa] <= (state_q == S_SWP) ? '0 : new_c[r];
			end
			rd_q[r] <= cnt_mem[it_addr_q[r]];
		end
	end

	assign parent   = (idx_q - IW'(1)) >> 1;
	assign lc       = ((LW + 1)'(idx_q) << 1) + (LW + 1)'(1);
	assign rc       = lc + (LW + 1)'(1);
	assign l_ok     = lc < (LW + 1)'(len_q);
	assign r_ok     = rc < (LW + 1)'(len_q);
	assign last_idx = (LW'(idx_q) + LW'(1)) == len_q;
	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = (state_q == S_IDLE) && q_valid;

	// heap port steering
	always_comb begin
		hr_addr = idx_q;
		hw_en   = 1'b0;
		hw_addr = idx_q;
		hw_est  = cur_est_q;
		hw_key  = cur_key_q;
		case (state_q)
			S_NEW: hr_addr = '0;
			S_UP:  hr_addr = parent;
			S_DN:  hr_addr = IW'(lc);
			S_DNL: hr_addr = IW'(rc);
			S_UPC: begin
				if (less(cur_est_q, cur_key_q, hr_est_q, hr_key_q)) begin
					hw_en  = 1'b1;
					hw_est = hr_est_q;
					hw_key = hr_key_q;
				end
			end
			S_FIN: hw_en = 1'b1;
			default: ;
		endcase
		if (state_q == S_DNL && !r_ok && less(hr_est_q, hr_key_q, cur_est_q, cur_key_q)) begin
			hw_en  = 1'b1;
			hw_est = hr_est_q;
			hw_key = hr_key_q;
		end
		if (state_q == S_DNR) begin
			if (less(hr_est_q, hr_key_q, lft_est_q, lft_key_q) &&
					less(hr_est_q, hr_key_q, cur_est_q, cur_key_q)) begin
				hw_en  = 1'b1;
				hw_est = hr_est_q;
				hw_key = hr_key_q;
			end else if (less(lft_est_q, lft_key_q, cur_est_q, cur_key_q)) begin
				hw_en  = 1'b1;
				hw_est = lft_est_q;
				hw_key = lft_key_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hw_en) begin
			h_est[hw_addr] <= hw_est;
			h_key[hw_addr] <= hw_key;
		end
		hr_est_q <= h_est[hr_addr];
		hr_key_q <= h_key[hr_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWP;
			sweep_q     <= '0;
			len_q       <= '0;
			idx_q       <= '0;
			search_q    <= 1'b0;
			scan_q      <= 1'b0;
			top_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_SWP: begin
					sweep_q <= sweep_q + BW'(1);
					if (sweep_q == BW'(BUCKETS - 1)) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						it_cmd_q  <= q_cmd;
						it_key_q  <= q_key;
						it_w_q    <= q_weight;
						it_addr_q <= q_addr;
						it_neg_q  <= q_neg;
						idx_q     <= '0;
						case (cst_pkg::cst_cmd_t'(q_cmd))
							cst_pkg::CMD_UPDATE: state_q <= S_RD;
							cst_pkg::CMD_REPORT: state_q <= (len_q == '0) ? S_MARK : S_REP;
							cst_pkg::CMD_CLEAR:  state_q <= S_MARK;
							default:             state_q <= S_IDLE;
						endcase
					end
				end
				S_RD: state_q <= S_OLD;
				S_OLD: begin
					old_est_q <= med(old_v);
					for (int r = 0; r < ROWS; r++) begin
						nv_q[r] <= new_v[r];
					end
					state_q <= S_NEW;
				end
				S_NEW: begin
					new_est_q <= med(nv_q);
					state_q   <= S_ROOT;
				end
				S_ROOT: begin
					root_est_q <= hr_est_q;
					scan_q     <= 1'b0;
					idx_q      <= '0;
					if (len_q != '0 && old_est_q >= hr_est_q) begin
						search_q <= 1'b1;
						state_q  <= S_SRCH;
					end else begin
						search_q <= 1'b0;
						state_q  <= S_INS;
					end
				end
				S_SRCH: state_q <= S_SCHK;
				S_SCHK: begin
					if (hr_key_q == it_key_q) begin
						if (scan_q) begin
							top_q   <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							cur_est_q <= new_est_q;
							cur_key_q <= it_key_q;
							state_q   <= S_UP;
						end
					end else if (last_idx) begin
						if (scan_q) begin
							top_q   <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_INS;
						end
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_SRCH;
					end
				end
				S_INS: begin
					cur_est_q <= new_est_q;
					cur_key_q <= it_key_q;
					if (len_q < LW'(TOP_K)) begin
						idx_q   <= IW'(len_q);
						len_q   <= len_q + LW'(1);
						state_q <= S_UP;
					end else if (new_est_q > root_est_q) begin
						idx_q   <= '0;
						state_q <= S_DN;
					end else if (search_q) begin
						top_q   <= 1'b0;
						state_q <= S_EMIT;
					end else begin
						// key may still sit in the heap: scan for it
						idx_q   <= '0;
						scan_q  <= 1'b1;
						state_q <= S_SRCH;
					end
				end
				S_UP: state_q <= (idx_q == '0) ? S_DN : S_UPC;
				S_UPC: begin
					if (less(cur_est_q, cur_key_q, hr_est_q, hr_key_q)) begin
						idx_q   <= parent;
						state_q <= S_UP;
					end else begin
						state_q <= S_DN;
					end
				end
				S_DN: state_q <= l_ok ? S_DNL : S_FIN;
				S_DNL: begin
					lft_est_q <= hr_est_q;
					lft_key_q <= hr_key_q;
					if (r_ok) begin
						state_q <= S_DNR;
					end else if (less(hr_est_q, hr_key_q, cur_est_q, cur_key_q)) begin
						idx_q   <= IW'(lc);
						state_q <= S_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DNR: begin
					if (less(hr_est_q, hr_key_q, lft_est_q, lft_key_q) &&
							less(hr_est_q, hr_key_q, cur_est_q, cur_key_q)) begin
						idx_q   <= IW'(rc);
						state_q <= S_DN;
					end else if (less(lft_est_q, lft_key_q, cur_est_q, cur_key_q)) begin
						idx_q   <= IW'(lc);
						state_q <= S_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					top_q   <= 1'b1;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						res_q       <= '{valid: 1'b1, key: it_key_q, est: sat32(new_est_q),
							top: top_q, last: 1'b1};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_REP: state_q <= S_REPE;
				S_REPE: begin
					if (out_free) begin
						res_q       <= '{valid: 1'b1, key: hr_key_q, est: sat32(hr_est_q),
							top: 1'b1, last: last_idx};
						out_valid_q <= 1'b1;
						if (last_idx) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= S_REP;
						end
					end
				end
				S_MARK: begin
					if (out_free) begin
						res_q       <= '{valid: 1'b0, key: '0, est: '0, top: 1'b0,
							last: 1'b1};
						out_valid_q <= 1'b1;
						if (cst_pkg::cst_cmd_t'(it_cmd_q) == cst_pkg::CMD_CLEAR) begin
							len_q   <= '0;
							sweep_q <= '0;
							state_q <= S_SWP;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	`include "count_sketch_top_k_tracker_defines.svh"

	`CST_ASSERT_NOW(heap_len_bound, 1'b1, len_q <= LW'(TOP_K), "heap length above capacity")
	`CST_ASSERT_NEXT(sweep_exit, state_q == S_SWP && sweep_q == BW'(BUCKETS - 1), state_q == S_IDLE, "sweep did not finish")
	`CST_ASSERT_NEXT(fin_nonempty, state_q == S_FIN, len_q != '0 && top_q, "heap write with empty heap")

endmodule

FILE: rtl/count_sketch_top_k_tracker.sv
// top level of the count sketch heavy-hitter tracker
`timescale 1ns / 1ps
// usage
// - input channel in_valid/in_ready carries one request: cmd, item_key, weight,
//   the five row buckets and sign_bits; a two-entry queue sits behind it, so
//   up to two requests are taken while the sequencer is busy
// - output channel out_valid/out_ready carries results from a result register;
//   a stalled receiver only holds the sequencer at its next emit
// - update: time is bounded by the heap search and sift through the single
//   read port of the heap memory
// - report: one result per heap entry; clear: one marker then a counter sweep
//   of all BUCKETS buckets, one bucket of every row per cycle
// - after reset the same sweep zeroes the sketch before the first request
//   leaves the queue
// - heap length returns to zero at reset and on clear
// - unassigned command 3 is dropped with no result
module count_sketch_top_k_tracker #(
	parameter int ROWS         = 5,
	parameter int BUCKETS      = 1024,
	parameter int TOP_K        = 16,
	parameter int COUNTER_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [31:0]        item_key,
	input  logic signed [31:0] weight,
	input  logic [9:0]         bucket_row0,
	input  logic [9:0]         bucket_row1,
	input  logic [9:0]         bucket_row2,
	input  logic [9:0]         bucket_row3,
	input  logic [9:0]         bucket_row4,
	input  logic [4:0]         sign_bits,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               entry_valid,
	output logic [31:0]        out_key,
	output logic signed [31:0] out_estimate,
	output logic               in_top,
	output logic               last
);
	localparam int BW = $clog2(BUCKETS);

	// queue between front and back
	logic                     q_valid, q_pop;
	logic [1:0]               q_cmd;
	logic [31:0]              q_key;
	logic signed [31:0]       q_weight;
	logic [ROWS-1:0][BW-1:0]  q_addr;
	logic [ROWS-1:0]          q_neg;
	cst_pkg::cst_res_t        res;

	// front: folds buckets into range and queues the request
	cst_front #(
		.ROWS    (ROWS),
		.BUCKETS (BUCKETS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.item_key    (item_key),
		.weight      (weight),
		.bucket_row0 (bucket_row0),
		.bucket_row1 (bucket_row1),
		.bucket_row2 (bucket_row2),
		.bucket_row3 (bucket_row3),
		.bucket_row4 (bucket_row4),
		.sign_bits   (sign_bits),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_cmd       (q_cmd),
		.q_key       (q_key),
		.q_weight    (q_weight),
		.q_addr      (q_addr),
		.q_neg       (q_neg)
	);

	// back: counters, heap and result register
	cst_back #(
		.ROWS         (ROWS),
		.BUCKETS      (BUCKETS),
		.TOP_K        (TOP_K),
		.COUNTER_BITS (COUNTER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_cmd     (q_cmd),
		.q_key     (q_key),
		.q_weight  (q_weight),
		.q_addr    (q_addr),
		.q_neg     (q_neg),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	// result fields onto their own ports
	assign entry_valid  = res.valid;
	assign out_key      = res.key;
	assign out_estimate = res.est;
	assign in_top       = res.top;
	assign last         = res.last;

endmodule
